// ----- hdl/lpfp_pkg.sv -----
package lpfp_pkg;

    localparam int LEN_W   = 25;
    localparam int SIZE_W  = 31;

    localparam logic [LEN_W-1:0] HEADER_BYTES  = 25'd9;
    localparam logic [LEN_W-1:0] TYPE_POS      = 25'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 25'd524288;

    localparam logic [7:0] TYPE_PLAIN  = 8'd0;
    localparam logic [7:0] TYPE_ZIPPED = 8'd1;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DROP  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;
        logic              last;
        logic              compressed;
        logic [SIZE_W-1:0] declared_size;
    } t_result;

endpackage

// ----- hdl/lpfp_in_if.sv -----
interface lpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hdl/lpfp_out_if.sv -----
interface lpfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic        compressed;
    logic [30:0] declared_size;

    modport source (output valid, output kind, output data, output last,
                    output compressed, output declared_size, input ready);
    modport sink   (input valid, input kind, input data, input last,
                    input compressed, input declared_size, output ready);
endinterface

// ----- hdl/lpfp_cfg_if.sv -----
interface lpfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [24:0] max_frame_length;

    modport source (output valid, output max_frame_length, input ready);
    modport sink   (input valid, input max_frame_length, output ready);
endinterface

// ----- hdl/lpfp_core.sv -----
module lpfp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [7:0]                    i_byte,
    input  logic [lpfp_pkg::LEN_W-1:0]    i_max_len,
    output logic                          o_res_valid,
    output lpfp_pkg::t_result             o_res
);

    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic [1:0]                 r_phase, n_phase;
    logic [lpfp_pkg::LEN_W-1:0] r_idx, n_idx;
    logic [31:0]                r_len, n_len;
    logic [lpfp_pkg::LEN_W-1:0] r_total, n_total;
    logic [7:0]                 r_type, n_type;
    logic [31:0]                r_dest, n_dest;
    logic [lpfp_pkg::LEN_W-1:0] r_left, n_left;
    logic                       r_stuck, n_stuck;

    logic [32:0]                w_total_ext;
    logic [lpfp_pkg::LEN_W-1:0] w_avail;
    logic                       w_zipped;
    logic                       w_drop;
    logic                       w_done;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_len   = r_len;
        n_total = r_total;
        n_type  = r_type;
        n_dest  = r_dest;
        n_left  = r_left;
        n_stuck = r_stuck;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_total_ext = {1'b0, r_len} + 33'd4;
        w_avail     = r_total - lpfp_pkg::HEADER_BYTES;
        w_zipped    = (r_type == lpfp_pkg::TYPE_ZIPPED);
        w_drop      = 1'b0;
        w_done      = 1'b0;

        if (r_stuck) begin
            o_res_valid = 1'b1;
            o_res.kind  = lpfp_pkg::KIND_ERROR;
        end else begin
            n_idx = r_idx + 25'd1;
            case (r_phase)
                PH_LENGTH: begin
                    case (r_idx[1:0])
                        2'd0:    n_len[7:0]   = i_byte;
                        2'd1:    n_len[15:8]  = i_byte;
                        2'd2:    n_len[23:16] = i_byte;
                        default: n_len[31:24] = i_byte;
                    endcase
                    w_total_ext = {1'b0, n_len} + 33'd4;
                    if (r_idx[1:0] == 2'd3) begin
                        if (w_total_ext > {8'd0, i_max_len} ||
                            w_total_ext < {8'd0, lpfp_pkg::HEADER_BYTES}) begin
                            n_stuck     = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = lpfp_pkg::KIND_ERROR;
                        end else begin
                            n_total = w_total_ext[lpfp_pkg::LEN_W-1:0];
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_HEADER: begin
                    case (r_idx[3:0])
                        4'd4:    n_type        = i_byte;
                        4'd5:    n_dest[7:0]   = i_byte;
                        4'd6:    n_dest[15:8]  = i_byte;
                        4'd7:    n_dest[23:16] = i_byte;
                        default: n_dest[31:24] = i_byte;
                    endcase
                    if (n_idx == lpfp_pkg::HEADER_BYTES) begin
                        // Declared size is complete with this byte
                        if (n_dest == 32'd0 || n_dest[31]) begin
                            w_drop = 1'b1;
                        end else if (r_type == lpfp_pkg::TYPE_PLAIN) begin
                            n_left = (n_dest < {7'd0, w_avail}) ?
                                     n_dest[lpfp_pkg::LEN_W-1:0] : w_avail;
                        end else if (w_zipped && n_dest < {7'd0, i_max_len}) begin
                            n_left = w_avail;
                        end else begin
                            w_drop = 1'b1;
                        end
                        if (w_drop) begin
                            n_left                 = '0;
                            o_res_valid            = 1'b1;
                            o_res.kind             = lpfp_pkg::KIND_DROP;
                            o_res.compressed       = w_zipped;
                            o_res.declared_size    = n_dest[30:0];
                        end
                        if (n_idx >= r_total) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_left != '0) begin
                        n_left              = r_left - 25'd1;
                        o_res_valid         = 1'b1;
                        o_res.kind          = lpfp_pkg::KIND_DATA;
                        o_res.data          = i_byte;
                        o_res.last          = (r_left == 25'd1);
                        o_res.compressed    = w_zipped;
                        o_res.declared_size = r_dest[30:0];
                    end
                    if (n_idx >= r_total) begin
                        w_done = 1'b1;
                    end
                end
                default: begin
                    w_done = 1'b1;
                end
            endcase
            // Start the next frame
            if (w_done) begin
                n_phase = PH_LENGTH;
                n_idx   = '0;
                n_len   = '0;
                n_total = '0;
                n_type  = '0;
                n_dest  = '0;
                n_left  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LENGTH;
            r_idx   <= '0;
            r_len   <= '0;
            r_total <= '0;
            r_type  <= '0;
            r_dest  <= '0;
            r_left  <= '0;
            r_stuck <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_total <= n_total;
            r_type  <= n_type;
            r_dest  <= n_dest;
            r_left  <= n_left;
            r_stuck <= n_stuck;
        end
    end

endmodule

// ----- hdl/length_prefixed_frame_parser_top.sv -----
// Channel  Dir  Fields                                          Handshake
// i_in     in   data_byte[7:0]                                  valid/ready
// o_res    out  kind[1:0] data[7:0] last compressed             valid/ready
//               declared_size[30:0]
// i_cfg    in   max_frame_length[24:0]                          valid/ready
//
// One byte per cycle: every byte is parsed in the cycle it is accepted and
// its result, if any, lands in the output register on the same edge.
// i_in.ready is high while the output register is empty or being drained,
// so input stalls only while a result waits there and o_res is not ready.
// Synchronous active-low reset clears the parser, the sticky error and the
// output valid flag, and loads max_frame_length with 524288.
module length_prefixed_frame_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpfp_in_if.sink       i_in,
    lpfp_out_if.source    o_res,
    lpfp_cfg_if.sink      i_cfg
);

    logic [lpfp_pkg::LEN_W-1:0] r_max_len;
    logic                       r_out_valid;
    lpfp_pkg::t_result          r_out;

    logic                       w_in_ready;
    logic                       w_accept;
    logic                       w_res_valid;
    lpfp_pkg::t_result          w_res;

    assign w_in_ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    lpfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_accept),
        .i_byte      (i_in.data_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpfp_pkg::MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.max_frame_length;
        end
    end

    // Advance the output register whenever it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_out_valid <= w_accept && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.data          = r_out.data;
    assign o_res.last          = r_out.last;
    assign o_res.compressed    = r_out.compressed;
    assign o_res.declared_size = r_out.declared_size;

endmodule
